[design/htfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the telemetry hub frame parser.
package htfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ID_W    = 6;
	localparam int unsigned VALUE_W = 16;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h5E;
	localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h5D;
	localparam logic [BYTE_W-1:0] ESC_MASK   = 8'h60;
	localparam logic [BYTE_W-1:0] ID_MAX     = 8'h3F;

	localparam logic [ID_W-1:0] ID_CAPACITY = 6'h04;
	localparam logic [ID_W-1:0] ID_CURRENT  = 6'h28;
	localparam logic [ID_W-1:0] ID_VOLTAGE  = 6'h39;
	localparam logic [ID_W-1:0] ID_WHOLE_V  = 6'h3A;
	localparam logic [ID_W-1:0] ID_FRAC_V   = 6'h3B;

	// Scaling of the split voltage: ((whole*100 + frac*10) * 210) / 110
	localparam int unsigned WHOLE_SCALE = 100;
	localparam int unsigned VALUE_SCALE = 10;
	localparam int unsigned RATIO_NUM   = 210;
	localparam int unsigned RATIO_DEN   = 110;
	localparam int unsigned RATIO_GCD   = 10;
	localparam int unsigned SCALE_MUL   = RATIO_NUM / RATIO_GCD;
	localparam int unsigned SCALE_DIV   = RATIO_DEN / RATIO_GCD;

	// Sum width: 65535*100 + 65535*10 fits in 23 bits; times 21 fits in 28 bits
	localparam int unsigned SUM_W  = 23;
	localparam int unsigned PROD_W = 28;

	// Reciprocal of SCALE_DIV, exact for every PROD_W-bit dividend
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned RECIP_W     = 29;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));
	localparam int unsigned RPROD_W = PROD_W + RECIP_W;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_ID   = 5'b00010,
		PH_LOW  = 5'b00100,
		PH_HIGH = 5'b01000,
		PH_END  = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPACITY,
		OP_CURRENT,
		OP_VOLTAGE,
		OP_VSCALE
	} op_t;

	typedef struct packed {
		logic               done;
		logic [ID_W-1:0]    id;
		logic [VALUE_W-1:0] value;
		op_t                op;
	} frame_info_t;

endpackage

[design/htfp_in_if.sv]
`timescale 1ns / 1ps
// Input byte channel of the telemetry hub frame parser.
interface htfp_in_if;
	logic                       valid;
	logic                       ready;
	logic [htfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/htfp_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the telemetry hub frame parser.
interface htfp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        frame_done;
	logic [htfp_pkg::ID_W-1:0]    frame_id;
	logic [htfp_pkg::VALUE_W-1:0] frame_value;
	logic [htfp_pkg::VALUE_W-1:0] voltage_reading;
	logic [htfp_pkg::VALUE_W-1:0] current_reading;
	logic [htfp_pkg::VALUE_W-1:0] capacity_reading;

	modport source (output valid, output frame_done, output frame_id, output frame_value,
		output voltage_reading, output current_reading, output capacity_reading,
		input ready);
	modport sink   (input valid, input frame_done, input frame_id, input frame_value,
		input voltage_reading, input current_reading, input capacity_reading,
		output ready);
endinterface

[design/hub_telemetry_frame_parser_unit.sv]
`timescale 1ns / 1ps
// A byte accepted at the input is registered through the parse, sum, scale and reciprocal divide
// stages in turn before it appears on the output.
// Throughput: one byte per cycle; each stage moves when it is empty or the next one moves,
// so bubbles absorb output stalls. The reciprocal multiply by 1/11 sets the last stage.
// Reset clears the parser, the readings and all stage valid bits; stage payloads are not reset.
module hub_telemetry_frame_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	htfp_in_if.sink           in_ch,
	htfp_out_if.source        out_ch
);

	// parser state
	htfp_pkg::phase_t                 phase_q, phase_d;
	logic                             esc_q, esc_d;
	logic [htfp_pkg::ID_W-1:0]        id_q, id_d;
	logic [htfp_pkg::BYTE_W-1:0]      low_q, low_d;
	logic [htfp_pkg::BYTE_W-1:0]      high_q, high_d;
	logic                             whole_seen_q;
	logic [htfp_pkg::VALUE_W-1:0]     whole_q;

	logic                             done_d;
	logic                             use_b;
	logic [htfp_pkg::BYTE_W-1:0]      data_b;
	htfp_pkg::op_t                    op_d;
	logic                             in_acc;

	// stage registers
	logic                             v_s1, v_s2, v_s3, v_s4;
	logic                             rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	htfp_pkg::frame_info_t            info_s1, info_s2, info_s3, info_s4;
	logic [htfp_pkg::VALUE_W-1:0]     whole_s1;
	logic [htfp_pkg::SUM_W-1:0]       sum_s2;
	logic [htfp_pkg::VALUE_W-1:0]     scaled_s2, scaled_s3;
	logic [htfp_pkg::PROD_W-1:0]      prod_s3;
	logic [htfp_pkg::RPROD_W-1:0]     recip_prod;
	logic [htfp_pkg::VALUE_W-1:0]     quot;

	// readings, updated as a transaction enters the output stage
	logic [htfp_pkg::VALUE_W-1:0]     voltage_q, current_q, capacity_q;

	assign rdy_s4 = !v_s4 || out_ch.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;
	assign in_acc = in_ch.valid && rdy_s1;

	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		id_d    = id_q;
		low_d   = low_q;
		high_d  = high_q;
		done_d  = 1'b0;
		use_b   = 1'b0;
		data_b  = in_ch.rx_byte;
		unique case (phase_q) inside
			htfp_pkg::PH_END: begin
				esc_d = 1'b0;
				if (in_ch.rx_byte == htfp_pkg::START_BYTE) begin
					done_d  = 1'b1;
					phase_d = htfp_pkg::PH_ID;
				end else begin
					phase_d = htfp_pkg::PH_IDLE;
				end
			end
			htfp_pkg::PH_ID, htfp_pkg::PH_LOW, htfp_pkg::PH_HIGH: begin
				if (in_ch.rx_byte == htfp_pkg::START_BYTE) begin
					phase_d = htfp_pkg::PH_ID;
					esc_d   = 1'b0;
				end else if (esc_q) begin
					data_b = in_ch.rx_byte ^ htfp_pkg::ESC_MASK;
					esc_d  = 1'b0;
					use_b  = 1'b1;
				end else if (in_ch.rx_byte == htfp_pkg::ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					use_b = 1'b1;
				end
				if (use_b) begin
					if (phase_q == htfp_pkg::PH_ID) begin
						if (data_b > htfp_pkg::ID_MAX) begin
							phase_d = htfp_pkg::PH_IDLE;
						end else begin
							id_d    = data_b[htfp_pkg::ID_W-1:0];
							phase_d = htfp_pkg::PH_LOW;
						end
					end else if (phase_q == htfp_pkg::PH_LOW) begin
						low_d   = data_b;
						phase_d = htfp_pkg::PH_HIGH;
					end else begin
						high_d  = data_b;
						phase_d = htfp_pkg::PH_END;
					end
				end
			end
			default: begin
				// idle and unreachable codes: wait for a start byte
				if (in_ch.rx_byte == htfp_pkg::START_BYTE) begin
					phase_d = htfp_pkg::PH_ID;
					esc_d   = 1'b0;
				end else begin
					phase_d = htfp_pkg::PH_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		op_d = htfp_pkg::OP_NONE;
		if (done_d) begin
			unique case (id_q)
				htfp_pkg::ID_CAPACITY: op_d = htfp_pkg::OP_CAPACITY;
				htfp_pkg::ID_CURRENT:  op_d = htfp_pkg::OP_CURRENT;
				htfp_pkg::ID_VOLTAGE:  op_d = htfp_pkg::OP_VOLTAGE;
				htfp_pkg::ID_FRAC_V:   op_d = whole_seen_q ? htfp_pkg::OP_VSCALE
				                                           : htfp_pkg::OP_NONE;
				default:               op_d = htfp_pkg::OP_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= htfp_pkg::PH_IDLE;
			esc_q        <= 1'b0;
			id_q         <= '0;
			low_q        <= '0;
			high_q       <= '0;
			whole_seen_q <= 1'b0;
			whole_q      <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			id_q    <= id_d;
			low_q   <= low_d;
			high_q  <= high_d;
			if (done_d && id_q == htfp_pkg::ID_WHOLE_V) begin
				whole_seen_q <= 1'b1;
				whole_q      <= {high_q, low_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_ch.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: parse result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			info_s1.done  <= done_d;
			info_s1.id    <= id_d;
			info_s1.value <= {high_d, low_d};
			info_s1.op    <= op_d;
			whole_s1      <= whole_q;
		end
	end

	// stage 2: weighted sum and plain times-ten scale
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			info_s2   <= info_s1;
			sum_s2    <= htfp_pkg::SUM_W'(whole_s1) * htfp_pkg::SUM_W'(htfp_pkg::WHOLE_SCALE)
			           + htfp_pkg::SUM_W'(info_s1.value)
			           * htfp_pkg::SUM_W'(htfp_pkg::VALUE_SCALE);
			scaled_s2 <= htfp_pkg::VALUE_W'(info_s1.value
			           * htfp_pkg::VALUE_W'(htfp_pkg::VALUE_SCALE));
		end
	end

	// stage 3: times 21
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			info_s3   <= info_s2;
			scaled_s3 <= scaled_s2;
			prod_s3   <= htfp_pkg::PROD_W'(sum_s2) * htfp_pkg::PROD_W'(htfp_pkg::SCALE_MUL);
		end
	end

	// stage 4: divide by 11 through the reciprocal, keep the wrapped low 16 quotient bits
	assign recip_prod = htfp_pkg::RPROD_W'(prod_s3) * htfp_pkg::RPROD_W'(htfp_pkg::RECIP_MUL);
	assign quot       = recip_prod[htfp_pkg::RECIP_SHIFT +: htfp_pkg::VALUE_W];

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			info_s4 <= info_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_q  <= '0;
			current_q  <= '0;
			capacity_q <= '0;
		end else if (v_s3 && rdy_s4) begin
			case (info_s3.op)
				htfp_pkg::OP_CAPACITY: capacity_q <= info_s3.value;
				htfp_pkg::OP_CURRENT:  current_q  <= scaled_s3;
				htfp_pkg::OP_VOLTAGE:  voltage_q  <= scaled_s3;
				htfp_pkg::OP_VSCALE:   voltage_q  <= quot;
				default: ;
			endcase
		end
	end

	assign out_ch.valid            = v_s4;
	assign out_ch.frame_done       = info_s4.done;
	assign out_ch.frame_id         = info_s4.id;
	assign out_ch.frame_value      = info_s4.value;
	assign out_ch.voltage_reading  = voltage_q;
	assign out_ch.current_reading  = current_q;
	assign out_ch.capacity_reading = capacity_q;

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		whole_seen_q |=> whole_seen_q)
		else $error("whole volts flag dropped");

	a_end_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == htfp_pkg::PH_END && in_ch.rx_byte == htfp_pkg::START_BYTE)
		|=> (v_s1 && info_s1.done))
		else $error("closing start byte did not complete a frame");

	a_vscale_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && info_s1.op == htfp_pkg::OP_VSCALE) |-> whole_seen_q)
		else $error("scaled voltage issued before whole volts seen");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ch.ready)
		else $error("input stalled while output stage empty");

endmodule
